@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the transit peak meter.
// No dependencies; each use sits on a line of its own inside a module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// Consequence checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/ctpm_pkg.sv @@
// Package for the coin transit peak meter: sizes, event codes and item types.
// No dependencies; imported by coin_transit_peak_meter_core.
`default_nettype none
package ctpm_pkg;

   // Ring length; must be a power of two so the average is a plain shift
   localparam int WINDOW_LEN  = 8;
   localparam int SAMPLE_BITS = 12;
   localparam int IDX_BITS    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int WIN_SHIFT   = $clog2(WINDOW_LEN);
   localparam int SUM_BITS    = SAMPLE_BITS + WIN_SHIFT;
   localparam int TIME_BITS   = 32;
   localparam int ADC_BITS    = 12;

   // Event codes
   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_END    = 2'd1;
   localparam logic [1:0] OP_SAMPLE = 2'd2;
   localparam logic [1:0] OP_TICK   = 2'd3;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [ADC_BITS-1:0] adc_sample;
   } req_item_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]   transit_time;
      logic [SAMPLE_BITS-1:0] peak_level;
   } rsp_item_type;

endpackage
`default_nettype wire

@@ hw/rtl/coin_transit_peak_meter_core.sv @@
// Coin transit peak meter: times one object between a start and an end edge
// and tracks the peak of an 8-sample moving average. Depends on ctpm_pkg.
//
// Usage: events (start, end, sample, tick) enter one item per cycle through a
// valid/stall channel into an input register. Each item updates the meter
// state in the cycle it leaves that register, so the sustained rate is one
// item per clock while no end edge is stalled. Only an end edge while
// measuring yields a result (transit time and peak level); it sits in an
// output register, and other events keep flowing while it waits. An end
// edge stalls only while an undelivered result still fills that register.
// No clearing pass after reset: a start edge clears the window.
`default_nettype none
`include "assert_macros.svh"
module coin_transit_peak_meter_core (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  ctpm_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output ctpm_pkg::rsp_item_type rsp_item
);
   import ctpm_pkg::*;

   // Input register
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;

   // Meter state
   logic                   measuring_ff, measuring_in;
   logic [TIME_BITS-1:0]   elapsed_ff, elapsed_in;
   logic [SAMPLE_BITS-1:0] window_ff [WINDOW_LEN];
   logic [SAMPLE_BITS-1:0] window_in [WINDOW_LEN];
   logic [IDX_BITS-1:0]    index_ff, index_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] peak_ff, peak_in;

   // Result register
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;

   logic                   req_accept, advance, emits, out_free;
   logic [SAMPLE_BITS-1:0] sample_val, avg_val;
   logic [SUM_BITS-1:0]    sum_next;

   // Handshake: an item leaves the input register unless it must emit into a full slot
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign emits      = (in_item_ff.opcode == OP_END) && measuring_ff;
   assign advance    = in_valid_ff && (out_free || !emits);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = out_valid_ff;
   assign rsp_item   = out_item_ff;

   assign in_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   // Running-sum update for a sample
   assign sample_val = in_item_ff.adc_sample[SAMPLE_BITS-1:0];
   assign sum_next   = sum_ff - SUM_BITS'(window_ff[index_ff]) + SUM_BITS'(sample_val);
   assign avg_val    = SAMPLE_BITS'(sum_next >> WIN_SHIFT);

   // Apply one event to the meter state
   always_comb begin
      measuring_in = measuring_ff;
      elapsed_in   = elapsed_ff;
      window_in    = window_ff;
      index_in     = index_ff;
      sum_in       = sum_ff;
      peak_in      = peak_ff;
      out_item_in  = out_item_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (advance) begin
         case (in_item_ff.opcode)
            OP_START: begin
               if (!measuring_ff) begin
                  measuring_in = 1'b1;
                  elapsed_in   = '0;
                  for (int i = 0; i < WINDOW_LEN; i++) begin
                     window_in[i] = '0;
                  end
                  index_in = '0;
                  sum_in   = '0;
                  peak_in  = '0;
               end
            end
            OP_TICK: begin
               if (measuring_ff && (elapsed_ff != '1)) begin
                  elapsed_in = elapsed_ff + TIME_BITS'(1);
               end
            end
            OP_SAMPLE: begin
               if (measuring_ff) begin
                  window_in[index_ff] = sample_val;
                  sum_in              = sum_next;
                  index_in = (index_ff == IDX_BITS'(WINDOW_LEN - 1)) ?
                             '0 : index_ff + IDX_BITS'(1);
                  if (avg_val > peak_ff) begin
                     peak_in = avg_val;
                  end
               end
            end
            OP_END: begin
               if (measuring_ff) begin
                  measuring_in             = 1'b0;
                  out_valid_in             = 1'b1;
                  out_item_in.transit_time = elapsed_ff;
                  out_item_in.peak_level   = peak_ff;
               end
            end
            default: begin
               measuring_in = measuring_ff;
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         measuring_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         measuring_ff <= measuring_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload and datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= req_item;
      end
      elapsed_ff  <= elapsed_in;
      window_ff   <= window_in;
      index_ff    <= index_in;
      sum_ff      <= sum_in;
      peak_ff     <= peak_in;
      out_item_ff <= out_item_in;
   end

   // Checks
   `ASSERT_IMPL(a_stall_needs_item, clock, reset, req_stall, in_valid_ff && out_valid_ff)
   `ASSERT_NEXT(a_end_emits, clock, reset, advance && emits, out_valid_ff && !measuring_ff)
   `ASSERT_NEXT(a_start_clears, clock, reset, advance && !measuring_ff && (in_item_ff.opcode == OP_START), measuring_ff && (sum_ff == '0) && (elapsed_ff == '0))
   `ASSERT_NEXT(a_peak_rises, clock, reset, measuring_ff, peak_ff >= $past(peak_ff))

endmodule
`default_nettype wire

@@ verif/coin_transit_peak_meter_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for coin_transit_peak_meter_core: a directed event table, then random
// transits with stalls on both sides. Depends on ctpm_pkg and the core RTL only.
module coin_transit_peak_meter_core_tb;
   import ctpm_pkg::*;

   localparam int CLOCK_HALF   = 5;
   localparam int EVENT_TARGET = 1100;
   localparam int CALM_TAIL    = 150;
   // Worst case per item is an idle gap, a result stall and its own transfer; keep a wide margin
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int BURST_MAX    = 16;

   typedef struct {
      req_item_type item;
      bit           typed;
      rsp_item_type want;
   } event_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_item;

   // Meter state mirrored by the bench
   bit                     meas_active;
   logic [TIME_BITS-1:0]   meas_elapsed;
   logic [SAMPLE_BITS-1:0] meas_window [WINDOW_LEN];
   logic [IDX_BITS-1:0]    meas_slot;
   logic [SUM_BITS-1:0]    meas_sum;
   logic [SAMPLE_BITS-1:0] meas_peak;

   rsp_item_type  pending_readings [$];
   event_row_type directed_events [$];
   rsp_item_type  oldest_reading;
   int            mismatch_count;
   int            events_sent;
   int            idle_odds = 4;
   int            cycle_count;
   int            stall_left;

   coin_transit_peak_meter_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Zero the measurement: count, window, sum, ring position and peak
   task automatic meter_clear();
      meas_elapsed = '0;
      foreach (meas_window[i]) meas_window[i] = '0;
      meas_slot = '0;
      meas_sum  = '0;
      meas_peak = '0;
   endtask

   // Advance the mirrored meter by one event; flag and return a reading on a live end edge
   task automatic meter_track(input req_item_type ev, output bit fired,
                              output rsp_item_type reading);
      logic [SAMPLE_BITS-1:0] value;
      logic [SUM_BITS-1:0]    avg;
      fired   = 1'b0;
      reading = '0;
      value   = ev.adc_sample[SAMPLE_BITS-1:0];
      case (ev.opcode)
         OP_START: begin
            if (!meas_active) begin
               meter_clear();
               meas_active = 1'b1;
            end
         end
         OP_TICK: begin
            if (meas_active && meas_elapsed != '1) meas_elapsed = meas_elapsed + 1'b1;
         end
         OP_SAMPLE: begin
            if (meas_active) begin
               meas_sum = meas_sum - meas_window[meas_slot] + value;
               meas_window[meas_slot] = value;
               meas_slot = (meas_slot == IDX_BITS'(WINDOW_LEN - 1)) ? '0 : meas_slot + 1'b1;
               avg = SUM_BITS'(meas_sum / WINDOW_LEN);
               if (avg > meas_peak) meas_peak = avg[SAMPLE_BITS-1:0];
            end
         end
         OP_END: begin
            if (meas_active) begin
               fired = 1'b1;
               reading.transit_time = meas_elapsed;
               reading.peak_level   = meas_peak;
               meas_active = 1'b0;
            end
         end
         default: begin
            fired = 1'b0;
         end
      endcase
   endtask

   function automatic req_item_type make_event(logic [1:0] op, logic [ADC_BITS-1:0] level);
      req_item_type ev;
      ev.opcode     = op;
      ev.adc_sample = level;
      return ev;
   endfunction

   // Mostly uniform readings, with the rails showing up often
   function automatic logic [ADC_BITS-1:0] random_level();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return ADC_BITS'($urandom_range(0, (1 << ADC_BITS) - 1));
      endcase
   endfunction

   task automatic add_row(logic [1:0] op, logic [ADC_BITS-1:0] level, bit typed = 1'b0,
                          logic [TIME_BITS-1:0] ticks = '0,
                          logic [SAMPLE_BITS-1:0] peak = '0);
      event_row_type row;
      row.item              = make_event(op, level);
      row.typed             = typed;
      row.want.transit_time = ticks;
      row.want.peak_level   = peak;
      directed_events.push_back(row);
   endtask

   // Offer one item, maybe after an idle burst; on acceptance record what it should produce
   task automatic push_event(input req_item_type ev, input bit typed = 1'b0,
                             input rsp_item_type want = '0);
      bit           fired;
      rsp_item_type reading;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_valid <= 1'b0;
         req_item  <= make_event(2'($urandom), random_level());
         repeat ($urandom_range(1, BURST_MAX)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= ev;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      meter_track(ev, fired, reading);
      if (typed) pending_readings.push_back(want);
      else if (fired) pending_readings.push_back(reading);
      events_sent++;
   endtask

   // Up to two events of any kind between transits
   task automatic stray_events();
      repeat ($urandom_range(0, 2)) push_event(make_event(2'($urandom), random_level()));
   endtask

   // Start, a run of samples and ticks with the odd repeated start, then usually an end
   task automatic run_transit();
      int span;
      int pick;
      push_event(make_event(OP_START, random_level()));
      span = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 24);
      repeat (span) begin
         pick = $urandom_range(0, 19);
         if (pick < 9) push_event(make_event(OP_SAMPLE, random_level()));
         else if (pick < 19) push_event(make_event(OP_TICK, random_level()));
         else push_event(make_event(OP_START, random_level()));
      end
      if ($urandom_range(0, 9) != 0) push_event(make_event(OP_END, random_level()));
   endtask

   // Hold off the sender until every reading is back
   task automatic drain_readings();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Result side: random stall bursts, none while idle_odds is zero
   initial begin
      rsp_stall <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (idle_odds == 0) stall_left = 0;
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (idle_odds != 0 && $urandom_range(1, 2 * idle_odds) == 1)
               stall_left = $urandom_range(1, BURST_MAX);
         end
      end
   end

   // Compare each delivered reading with the oldest one expected
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected reading, expected none, actual time %0d peak %0d",
                     $time, rsp_item.transit_time, rsp_item.peak_level);
            mismatch_count++;
         end else begin
            oldest_reading = pending_readings.pop_front();
            if (rsp_item.transit_time !== oldest_reading.transit_time) begin
               $display("%0t: transit_time expected %0d actual %0d",
                        $time, oldest_reading.transit_time, rsp_item.transit_time);
               mismatch_count++;
            end
            if (rsp_item.peak_level !== oldest_reading.peak_level) begin
               $display("%0t: peak_level expected %0d actual %0d",
                        $time, oldest_reading.peak_level, rsp_item.peak_level);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_item  <= '0;
      mismatch_count = 0;
      events_sent    = 0;
      meas_active    = 1'b0;
      meter_clear();

      // Stray events in idle, an empty transit, a saturated window across an ignored start,
      // a zero-level transit, then a mixed-bit pair left to the model
      add_row(OP_END, '0);
      add_row(OP_TICK, '1);
      add_row(OP_SAMPLE, '1);
      add_row(OP_START, '0);
      add_row(OP_END, '0, 1'b1, '0, '0);
      add_row(OP_START, '1);
      repeat (WINDOW_LEN) add_row(OP_SAMPLE, '1);
      add_row(OP_TICK, '0);
      add_row(OP_START, '0);
      add_row(OP_TICK, '0);
      add_row(OP_END, '1, 1'b1, TIME_BITS'(2), '1);
      add_row(OP_START, '0);
      add_row(OP_SAMPLE, '0);
      add_row(OP_TICK, '1);
      add_row(OP_END, '0, 1'b1, TIME_BITS'(1), '0);
      add_row(OP_START, '0);
      add_row(OP_SAMPLE, 12'hAAA);
      add_row(OP_SAMPLE, 12'h555);
      add_row(OP_END, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      foreach (directed_events[i])
         push_event(directed_events[i].item, directed_events[i].typed, directed_events[i].want);
      drain_readings();

      // Random transits, changing the idle pressure now and then
      while (events_sent < EVENT_TARGET - CALM_TAIL) begin
         if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 2))
               0:       idle_odds = 0;
               1:       idle_odds = 3;
               default: idle_odds = 8;
            endcase
         end
         stray_events();
         run_transit();
      end

      // Calm tail: no idling on either side
      idle_odds = 0;
      while (events_sent < EVENT_TARGET) begin
         stray_events();
         run_transit();
      end
      drain_readings();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/ctpm_pkg.sv
hw/rtl/coin_transit_peak_meter_core.sv
verif/coin_transit_peak_meter_core_tb.sv
